[hw/rtl/trq_pkg.sv]
// Shared types and constants for the timestamp request queue.
// No dependencies; imported by every trq module and the top level.
package trq_pkg;

    localparam int DEF_SLOTS = 16;
    localparam int FUNC_W    = 2;
    localparam int PROC_W    = 8;
    localparam int TIME_W    = 16;
    localparam int KEY_W     = TIME_W + PROC_W;

    typedef enum logic [FUNC_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_HEAD    = 2'd2
    } func_t;

    // Lamport order key: time in the upper bits, process id below
    typedef logic [KEY_W-1:0] key_t;

    // status of one transaction after the table update
    typedef struct packed {
        logic vld;
        logic ok;
    } op_status_t;

endpackage

[hw/rtl/trq_slot_table.sv]
// Slot table: holds the pending requests and applies enqueue and release.
// Depends on trq_pkg.
module trq_slot_table
    import trq_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [FUNC_W-1:0] func,
    input  logic [PROC_W-1:0] proc_id,
    input  logic [TIME_W-1:0] req_time,
    output key_t              slot_key [SLOTS],
    output op_status_t        status
);

    logic [TIME_W-1:0] time_reg [SLOTS];
    logic [TIME_W-1:0] time_next [SLOTS];
    logic [PROC_W-1:0] proc_reg [SLOTS];
    logic [PROC_W-1:0] proc_next [SLOTS];
    logic [SLOTS-1:0]  pending;
    logic [SLOTS-1:0]  empty_sel;
    logic [SLOTS-1:0]  match;
    logic [SLOTS-1:0]  match_sel;
    logic              enq;
    logic              rel;
    logic              ok;
    op_status_t        status_reg;
    op_status_t        status_next;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            pending[i]  = (time_reg[i] != '0) || (proc_reg[i] != '0);
            match[i]    = pending[i] && (proc_reg[i] == proc_id);
            slot_key[i] = {time_reg[i], proc_reg[i]};
        end
    end

    // lowest set bit isolates the first candidate slot
    assign empty_sel = ~pending & (pending + SLOTS'(1));
    assign match_sel = match & (~match + SLOTS'(1));

    always_comb
    begin
        enq = 1'b0;
        rel = 1'b0;
        ok  = 1'b0;
        case (func_t'(func))
            OP_ENQUEUE:
            begin
                enq = in_vld;
                ok  = |empty_sel;
            end
            OP_RELEASE:
            begin
                rel = in_vld;
                ok  = |match_sel;
            end
            OP_HEAD:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            time_next[i] = time_reg[i];
            proc_next[i] = proc_reg[i];
            if (enq && empty_sel[i])
            begin
                time_next[i] = req_time;
                proc_next[i] = proc_id;
            end
            else if (rel && match_sel[i])
            begin
                time_next[i] = '0;
                proc_next[i] = '0;
            end
        end
        status_next.vld = in_vld;
        status_next.ok  = ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                time_reg[i] <= '0;
                proc_reg[i] <= '0;
            end
            status_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                time_reg[i] <= time_next[i];
                proc_reg[i] <= proc_next[i];
            end
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

[hw/rtl/trq_head_tree.sv]
// Head search: compare tree for the smallest pending key, plus result register.
// Depends on trq_pkg.
module trq_head_tree
    import trq_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_t              slot_key [SLOTS],
    input  op_status_t        status,
    output logic              strobe,
    output logic              done_ok,
    output logic              head_valid,
    output logic [PROC_W-1:0] head_proc,
    output logic [TIME_W-1:0] head_time
);

    localparam int LEAVES = 1 << $clog2(SLOTS);

    logic node_vld [1:2*LEAVES-1];
    key_t node_key [1:2*LEAVES-1];

    logic              strobe_reg;
    logic              strobe_next;
    logic              ok_reg;
    logic              ok_next;
    logic              hvld_reg;
    logic              hvld_next;
    key_t              hkey_reg;
    key_t              hkey_next;

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < SLOTS)
            begin : g_used
                assign node_vld[LEAVES+g] = (slot_key[g] != '0);
                assign node_key[LEAVES+g] = slot_key[g];
            end
            else
            begin : g_pad
                assign node_vld[LEAVES+g] = 1'b0;
                assign node_key[LEAVES+g] = '0;
            end
        end
        // left child wins ties, so the lower slot is reported
        for (g = 1; g < LEAVES; g++)
        begin : g_node
            logic take_left;
            assign take_left   = node_vld[2*g] &&
                                 (!node_vld[2*g+1] || (node_key[2*g] <= node_key[2*g+1]));
            assign node_vld[g] = node_vld[2*g] || node_vld[2*g+1];
            assign node_key[g] = take_left ? node_key[2*g] :
                                 (node_vld[2*g+1] ? node_key[2*g+1] : '0);
        end
    endgenerate

    always_comb
    begin
        strobe_next = status.vld;
        ok_next     = status.ok;
        hvld_next   = node_vld[1];
        hkey_next   = node_key[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        hvld_reg <= hvld_next;
        hkey_reg <= hkey_next;
    end

    assign strobe     = strobe_reg;
    assign done_ok    = ok_reg;
    assign head_valid = hvld_reg;
    assign head_time  = hkey_reg[KEY_W-1:PROC_W];
    assign head_proc  = hkey_reg[PROC_W-1:0];

endmodule

[hw/rtl/timestamp_request_queue_unit.sv]
// Top level of the timestamp request queue: input register, slot table, head search.
// Depends on trq_pkg, trq_slot_table and trq_head_tree.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   func selects enqueue, release or report head; proc_id and req_time
//   carry the request. busy is always low: one transaction per cycle.
//   Each transaction yields one result, shown for a single cycle with
//   strobe high: done_ok, head_valid, head_proc, head_time.
//   The input register loads at the accepting edge, the table update then
//   registers the status, and the head search then loads the result
//   register that drives strobe.
//   Throughput: one transaction per cycle. The head is the smallest
//   {time, id} among pending slots, searched by a combinational compare tree
//   over the registered table, so its depth sets the clock period.
//   Reset empties every slot and drops anything in flight; no strobe
//   follows until a new transaction arrives.
//   The receiver cannot stall: a result not taken in its strobe cycle is gone.
module timestamp_request_queue_unit
    import trq_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [PROC_W-1:0] proc_id,
    input  logic [TIME_W-1:0] req_time,
    output logic              strobe,
    output logic              done_ok,
    output logic              head_valid,
    output logic [PROC_W-1:0] head_proc,
    output logic [TIME_W-1:0] head_time
);

    logic              in_vld_reg;
    logic              in_vld_next;
    logic [FUNC_W-1:0] func_reg;
    logic [PROC_W-1:0] proc_reg;
    logic [TIME_W-1:0] time_reg;
    key_t              slot_key [SLOTS];
    op_status_t        status;

    assign busy        = 1'b0;
    assign in_vld_next = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func;
        proc_reg <= proc_id;
        time_reg <= req_time;
    end

    trq_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .func     (func_reg),
        .proc_id  (proc_reg),
        .req_time (time_reg),
        .slot_key (slot_key),
        .status   (status)
    );

    trq_head_tree #(
        .SLOTS (SLOTS)
    ) u_head (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_key   (slot_key),
        .status     (status),
        .strobe     (strobe),
        .done_ok    (done_ok),
        .head_valid (head_valid),
        .head_proc  (head_proc),
        .head_time  (head_time)
    );

    // every registered transaction reaches the table stage next cycle
    a_in_to_table: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> status.vld)
        else $error("transaction lost between input register and table");

    a_table_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        status.vld |=> strobe)
        else $error("table stage transaction produced no strobe");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !status.vld |=> !strobe)
        else $error("strobe without a transaction");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !head_valid) |-> (head_proc == '0 && head_time == '0))
        else $error("empty table reported a nonzero head");

    a_valid_head: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && head_valid) |-> (head_proc != '0 || head_time != '0))
        else $error("valid head carries the empty pattern");

endmodule

[sim/tb_timestamp_request_queue_unit.sv]
// Testbench for timestamp_request_queue_unit: directed and random enqueue, release,
// report-head and unused-code transactions, checked against a Lamport-order table model.
// Depends on trq_pkg and the RTL of timestamp_request_queue_unit.
module tb_timestamp_request_queue_unit
    import trq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                SLOTS      = DEF_SLOTS;
    localparam logic [FUNC_W-1:0] OP_UNUSED  = 2'd3;
    localparam int                N_RANDOM   = 600;
    localparam int                CYCLE_CAP  = 200000;
    localparam int                DRAIN_WAIT = 8;
    localparam int                PRINT_CAP  = 20;

    typedef struct {
        logic              pause;
        logic [FUNC_W-1:0] op;
        logic [PROC_W-1:0] pid;
        logic [TIME_W-1:0] t;
    } table_op_t;

    typedef struct packed {
        logic              ok;
        logic              hv;
        logic [PROC_W-1:0] hp;
        logic [TIME_W-1:0] ht;
    } head_report_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic [FUNC_W-1:0] func     = '0;
    logic [PROC_W-1:0] proc_id  = '0;
    logic [TIME_W-1:0] req_time = '0;
    logic              busy;
    logic              strobe;
    logic              done_ok;
    logic              head_valid;
    logic [PROC_W-1:0] head_proc;
    logic [TIME_W-1:0] head_time;

    // model copy of the request table
    logic [TIME_W-1:0] tbl_time [SLOTS];
    logic [PROC_W-1:0] tbl_proc [SLOTS];

    table_op_t    pending_ops[$];
    head_report_t expected_heads[$];

    int err_cnt       = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int cycle_cnt     = 0;
    int gap_left      = 0;
    bit steady_mode   = 1'b0;
    int n_op [4]      = '{0, 0, 0, 0};
    int n_full_reject = 0;
    int n_release_miss = 0;
    int peak_fill     = 0;
    int n_empty_head  = 0;

    timestamp_request_queue_unit #(.SLOTS(SLOTS)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .proc_id    (proc_id),
        .req_time   (req_time),
        .strobe     (strobe),
        .done_ok    (done_ok),
        .head_valid (head_valid),
        .head_proc  (head_proc),
        .head_time  (head_time)
    );

    always #2 clk = ~clk;

    function automatic bit slot_busy(int i);
        return tbl_time[i] != '0 || tbl_proc[i] != '0;
    endfunction

    // apply one transaction to the model table and return the head after it
    function automatic head_report_t apply_table_op(logic [FUNC_W-1:0] op,
                                                    logic [PROC_W-1:0] pid,
                                                    logic [TIME_W-1:0] t);
        head_report_t r;
        logic         ok;
        logic         hit;
        logic         found;
        key_t         best;
        key_t         k;
        int           fill;
        ok    = 1'b0;
        hit   = 1'b0;
        found = 1'b0;
        best  = '0;
        fill  = 0;
        r     = '0;
        n_op[op]++;
        case (op)
            OP_ENQUEUE:
            begin
                for (int i = 0; i < SLOTS && !hit; i++)
                begin
                    if (!slot_busy(i))
                    begin
                        tbl_time[i] = t;
                        tbl_proc[i] = pid;
                        hit = 1'b1;
                    end
                end
                ok = hit;
                if (!hit)
                    n_full_reject++;
            end
            OP_RELEASE:
            begin
                for (int i = 0; i < SLOTS && !hit; i++)
                begin
                    if (slot_busy(i) && tbl_proc[i] == pid)
                    begin
                        tbl_time[i] = '0;
                        tbl_proc[i] = '0;
                        hit = 1'b1;
                    end
                end
                ok = hit;
                if (!hit)
                    n_release_miss++;
            end
            OP_HEAD: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_busy(i))
            begin
                fill++;
                k = {tbl_time[i], tbl_proc[i]};
                if (!found || k < best)
                begin
                    found = 1'b1;
                    best  = k;
                    r.hp  = tbl_proc[i];
                    r.ht  = tbl_time[i];
                end
            end
        end
        if (fill > peak_fill)
            peak_fill = fill;
        if (!found)
            n_empty_head++;
        r.ok = ok;
        r.hv = found;
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        if ($urandom_range(0, 99) < 2)
            steady_mode = !steady_mode;
        if (steady_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    task automatic add_op(logic [FUNC_W-1:0] op, logic [PROC_W-1:0] pid,
                          logic [TIME_W-1:0] t);
        table_op_t e;
        e.pause = 1'b0;
        e.op    = op;
        e.pid   = pid;
        e.t     = t;
        pending_ops.push_back(e);
    endtask

    task automatic add_pause();
        table_op_t e;
        e       = '{default: '0};
        e.pause = 1'b1;
        pending_ops.push_back(e);
    endtask

    task automatic report_mismatch(string what);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // driver: record the accepted transaction, then present the next one
    always @(posedge clk)
    begin
        table_op_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_heads.push_back(apply_table_op(func, proc_id, req_time));
                sent_cnt++;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_ops.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (pending_ops[0].pause)
                begin
                    // hold off until every outstanding result is back
                    if (expected_heads.size() == 0)
                        void'(pending_ops.pop_front());
                    start <= 1'b0;
                end
                else
                begin
                    nxt      = pending_ops.pop_front();
                    start    <= 1'b1;
                    func     <= nxt.op;
                    proc_id  <= nxt.pid;
                    req_time <= nxt.t;
                    gap_left <= draw_gap();
                end
            end
        end
    end

    // monitor: each strobe is checked against the oldest expectation
    always @(posedge clk)
    begin
        head_report_t want;
        if (rst_n && strobe)
        begin
            if (expected_heads.size() == 0)
            begin
                report_mismatch("result strobe with no transaction outstanding");
            end
            else
            begin
                want = expected_heads.pop_front();
                checked_cnt++;
                if (done_ok !== want.ok)
                    report_mismatch($sformatf("result %0d done_ok %b, want %b",
                                              checked_cnt, done_ok, want.ok));
                if (head_valid !== want.hv)
                    report_mismatch($sformatf("result %0d head_valid %b, want %b",
                                              checked_cnt, head_valid, want.hv));
                if (head_proc !== want.hp)
                    report_mismatch($sformatf("result %0d head_proc %h, want %h",
                                              checked_cnt, head_proc, want.hp));
                if (head_time !== want.ht)
                    report_mismatch($sformatf("result %0d head_time %h, want %h",
                                              checked_cnt, head_time, want.ht));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_heads.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int enq_pct;
        int r;
        logic [FUNC_W-1:0] op;
        logic [PROC_W-1:0] pid;
        logic [TIME_W-1:0] t;

        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_time[i] = '0;
            tbl_proc[i] = '0;
        end

        // directed: empty table, empty-pattern enqueue, unused code, extremes,
        // duplicates, id 0 pending, fill to full, enqueue on full
        add_op(OP_HEAD, 8'h00, 16'h0000);
        add_op(OP_RELEASE, 8'h00, 16'h0000);
        add_op(OP_ENQUEUE, 8'h00, 16'h0000);
        add_op(OP_UNUSED, 8'hFF, 16'hFFFF);
        add_op(OP_ENQUEUE, 8'hFF, 16'hFFFF);
        add_op(OP_ENQUEUE, 8'h00, 16'h0001);
        add_op(OP_ENQUEUE, 8'h01, 16'h0000);
        add_op(OP_ENQUEUE, 8'h07, 16'd100);
        add_op(OP_ENQUEUE, 8'h07, 16'd100);
        add_op(OP_RELEASE, 8'h07, 16'h0000);
        add_op(OP_RELEASE, 8'h00, 16'hFFFF);
        add_op(OP_RELEASE, 8'h00, 16'h0000);
        add_op(OP_HEAD, 8'hA5, 16'h5A5A);
        for (int i = 0; i < SLOTS - 3; i++)
            add_op(OP_ENQUEUE, 8'(8'h80 + i), 16'(16'h8000 - 16'(i)));
        add_op(OP_ENQUEUE, 8'h02, 16'h0002);
        add_op(OP_UNUSED, 8'h00, 16'h0000);
        add_pause();

        // random: bursts that lean toward filling or draining the table
        enq_pct = 50;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 40 == 0)
            begin
                r = $urandom_range(0, 2);
                enq_pct = (r == 0) ? 80 : (r == 1) ? 20 : 50;
            end
            if (n == 200 || n == 400)
                add_pause();
            pid = ($urandom_range(0, 99) < 70) ? PROC_W'($urandom_range(0, 15))
                                               : PROC_W'($urandom);
            t   = ($urandom_range(0, 1) == 0) ? TIME_W'($urandom_range(0, 7))
                                              : TIME_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < enq_pct)
            begin
                op = OP_ENQUEUE;
                if ($urandom_range(0, 19) == 0)
                begin
                    pid = '0;
                    t   = '0;
                end
            end
            else if (r < 90)
            begin
                op = OP_RELEASE;
            end
            else if (r < 97)
            begin
                op = OP_HEAD;
            end
            else
            begin
                op = OP_UNUSED;
            end
            add_op(op, pid, t);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start)
            @(posedge clk);
        while (expected_heads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d transactions: %0d enqueue, %0d release, %0d head, %0d unused;",
                 sent_cnt, n_op[OP_ENQUEUE], n_op[OP_RELEASE], n_op[OP_HEAD],
                 n_op[OP_UNUSED]);
        $display("  %0d checked, peak fill %0d/%0d, %0d full-table enqueues, %0d %s",
                 checked_cnt, peak_fill, SLOTS, n_full_reject, n_release_miss,
                 $sformatf("release misses, %0d empty heads", n_empty_head));
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
